// ===== hdl/pasc_pkg.sv =====
// shared types and constants of the periodic advection stencil core
// used by pasc_ctrl, pasc_dpath and the top level; depends on nothing
package pasc_pkg;

  // grid limits
  localparam int MAX_POINTS = 4096;
  localparam int CNT_W      = $clog2(MAX_POINTS);
  localparam int IDX_W      = 12;

  // value widths: samples Q8.24, alpha Q2.30, wide sums and products
  localparam int VAL_W  = 32;
  localparam int DIFF_W = 36;
  localparam int MULA_W = 34;
  localparam int PROD_W = 70;
  localparam int SUM_W  = 40;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_ALPHA = 2'd1;
  localparam logic [31:0] ALPHA_RESET = 32'h2000_0000;

  // scheme codes
  localparam logic [2:0] MODE_UPWIND = 3'd0;
  localparam logic [2:0] MODE_FWD    = 3'd1;
  localparam logic [2:0] MODE_FTCS   = 3'd2;
  localparam logic [2:0] MODE_LEAP   = 3'd3;
  localparam logic [2:0] MODE_LW     = 3'd4;
  localparam logic [2:0] MODE_LAX    = 3'd5;

  // which result of an item is being computed
  localparam logic [1:0] RES_MID  = 2'd0;  // point n-1
  localparam logic [1:0] RES_LAST = 2'd1;  // point n on the last point
  localparam logic [1:0] RES_WRAP = 2'd2;  // point 0 on the last point

  // multiply steps of one result
  localparam logic [1:0] STEP_FIRST = 2'd0;
  localparam logic [1:0] STEP_MID   = 2'd1;
  localparam logic [1:0] STEP_LAST  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       setup;
    logic       mul_lo;
    logic       mul_hi;
    logic       load_out;
    logic       short_out;
    logic       commit;
    logic [1:0] step;
    logic [1:0] res_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic short_pass;
    logic warm_up;
    logic last;
    logic lw_mode;
    logic out_free;
  } status_t;

  // reserved codes fall back to upwind
  function automatic logic [2:0] norm_mode(input logic [2:0] m);
    logic [2:0] r;
    case (m)
      MODE_FWD, MODE_FTCS, MODE_LEAP, MODE_LW, MODE_LAX: r = m;
      default: r = MODE_UPWIND;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/periodic_advection_stencil_core.sv =====
// Periodic 1D advection stencil: grid points of one pass stream in from index 0,
// one word per point; the new value of point i-1 leaves when point i arrives, and
// the last point (or index 4095) also yields points N-1 and 0, the final word
// flagged pass_done. A pass of one or two points yields a single short_pass word.
// One word at a time is processed: a point that only fills the window is just stored;
// each result runs setup, low and high multiply steps and a final sum, setup and multiply
// repeated for each of three multiplies in Lax-Wendroff mode, on the shared 17x36 multiplier
// that also forms alpha squared. The output register lets the next point enter while a
// result waits. The user must write scheme and alpha only while the core is idle; the core does not enforce it.
module periodic_advection_stencil_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sample_value_i,
  input  logic signed [31:0] older_value_i,
  input  logic               last_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [11:0]        point_index_o,
  output logic signed [31:0] new_value_o,
  output logic               pass_done_o,
  output logic               saturated_o,
  output logic               short_pass_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import pasc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  pasc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  pasc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_value_i (sample_value_i),
    .older_value_i  (older_value_i),
    .last_point_i   (last_point_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .point_index_o  (point_index_o),
    .new_value_o    (new_value_o),
    .pass_done_o    (pass_done_o),
    .saturated_o    (saturated_o),
    .short_pass_o   (short_pass_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

// ===== hdl/pasc_ctrl.sv =====
// sequencer of the periodic advection stencil core
// depends on pasc_pkg for the command and status structs
module pasc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pasc_pkg::status_t  status_i,
  output pasc_pkg::cmd_t     cmd_o
);
  import pasc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SETUP  = 6'b000100,
    S_LO     = 6'b001000,
    S_HI     = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  // short passes reuse the fin state with a flag
  state_e     state_q, state_d;
  logic [1:0] res_q, res_d;
  logic [1:0] step_q, step_d;
  logic       short_q, short_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_MID;
      step_q  <= STEP_FIRST;
      short_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      step_q  <= step_d;
      short_q <= short_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    step_d  = step_q;
    short_d = short_q;
    cmd_o   = '0;
    cmd_o.step    = step_q;
    cmd_o.res_sel = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_d   = RES_MID;
        step_d  = STEP_FIRST;
        short_d = 1'b0;
        if (status_i.short_pass) begin
          short_d = 1'b1;
          state_d = S_FIN;
        end else if (status_i.warm_up) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = S_LO;
      end
      S_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_HI;
      end
      S_HI: begin
        cmd_o.mul_hi = 1'b1;
        if (status_i.lw_mode && step_q != STEP_LAST) begin
          step_d  = step_q + 2'd1;
          state_d = S_SETUP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (status_i.out_free) begin
          if (short_q) begin
            cmd_o.short_out = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.load_out = 1'b1;
            if (status_i.last && res_q != RES_WRAP) begin
              res_d   = res_q + 2'd1;
              step_d  = STEP_FIRST;
              state_d = S_SETUP;
            end else begin
              cmd_o.commit = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/pasc_dpath.sv =====
// datapath of the periodic advection stencil core: window, config,
// shared multiplier, final sum with saturation, output register
// depends on pasc_pkg
module pasc_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [31:0]      sample_value_i,
  input  logic signed [31:0]      older_value_i,
  input  logic                    last_point_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [11:0]             point_index_o,
  output logic signed [31:0]      new_value_o,
  output logic                    pass_done_o,
  output logic                    saturated_o,
  output logic                    short_pass_o,
  input  pasc_pkg::cmd_t          cmd_i,
  output pasc_pkg::status_t       status_o
);
  import pasc_pkg::*;

  // configuration
  logic [2:0]  mode_q;
  logic [31:0] alpha_q;

  // pass state and captured word
  logic [CNT_W-1:0]        cnt_q;
  logic signed [VAL_W-1:0] first_sample_q, second_sample_q, first_older_q;
  logic signed [VAL_W-1:0] wb2_q, wb1_q, ob1_q, cur_q, old_q;
  logic                    last_q;

  // arithmetic registers
  logic signed [SUM_W-1:0]  base_q, m1_q;
  logic signed [DIFF_W-1:0] d_q;
  logic [MULA_W-1:0]        mul_a_q, a2_q;
  logic                     rnd31_q;
  logic signed [PROD_W-1:0] prod_q;

  // output register
  logic                    out_valid_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    done_q, sat_q, short_q;

  logic [2:0]               mode;
  logic                     lw;
  logic signed [VAL_W-1:0]  op_l, op_c, op_r, op_o;
  logic signed [DIFF_W-1:0] l36, c36, r36;
  logic signed [DIFF_W-1:0] d_cl, d_rc, d_rl, d_2;
  logic signed [VAL_W:0]    lax_sum;
  logic signed [SUM_W-1:0]  base;
  logic signed [53:0]       pp;
  logic signed [PROD_W-1:0] pp_ext, bias;
  logic signed [SUM_W-1:0]  m1, m2, v;
  logic                     sat_hi, sat_lo;
  logic [IDX_W-1:0]         idx;
  logic                     out_free;

  assign mode = norm_mode(mode_q);
  assign lw   = (mode == MODE_LW);
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.short_pass = last_q && (cnt_q < CNT_W'(2));
  assign status_o.warm_up    = (cnt_q < CNT_W'(2));
  assign status_o.last       = last_q;
  assign status_o.lw_mode    = lw;
  assign status_o.out_free   = out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_UPWIND;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[2:0];
        CFG_ALPHA: alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // neighbor selection for the result being computed
  always_comb begin
    case (cmd_i.res_sel)
      RES_LAST: begin
        op_l = wb1_q; op_c = cur_q; op_r = first_sample_q; op_o = old_q;
      end
      RES_WRAP: begin
        op_l = cur_q; op_c = first_sample_q; op_r = second_sample_q;
        op_o = first_older_q;
      end
      default: begin
        op_l = wb2_q; op_c = wb1_q; op_r = cur_q; op_o = ob1_q;
      end
    endcase
  end

  // differences and base term
  assign l36  = {{(DIFF_W-VAL_W){op_l[VAL_W-1]}}, op_l};
  assign c36  = {{(DIFF_W-VAL_W){op_c[VAL_W-1]}}, op_c};
  assign r36  = {{(DIFF_W-VAL_W){op_r[VAL_W-1]}}, op_r};
  assign d_cl = c36 - l36;
  assign d_rc = r36 - c36;
  assign d_rl = r36 - l36;
  assign d_2  = r36 - (c36 <<< 1) + l36;
  assign lax_sum = {op_r[VAL_W-1], op_r} + {op_l[VAL_W-1], op_l} + 33'sd1;

  always_comb begin
    case (mode)
      MODE_LAX:  base = {{(SUM_W-VAL_W){lax_sum[VAL_W]}}, lax_sum[VAL_W:1]};
      MODE_LEAP: base = {{(SUM_W-VAL_W){op_o[VAL_W-1]}}, op_o};
      default:   base = {{(SUM_W-VAL_W){op_c[VAL_W-1]}}, op_c};
    endcase
  end

  // shared multiplier: low half of a with rounding bias, then high half
  assign pp     = (cmd_i.mul_lo ? $signed({1'b0, mul_a_q[16:0]})
                                : $signed({1'b0, mul_a_q[33:17]})) * d_q;
  assign pp_ext = {{(PROD_W-54){pp[53]}}, pp};
  assign bias   = rnd31_q ? (PROD_W'(1) <<< 30) : (PROD_W'(1) <<< 29);

  // operand setup and multiply steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      if (cmd_i.step == STEP_FIRST) begin
        base_q <= base;
      end
      mul_a_q <= {2'b00, alpha_q};
      if (lw) begin
        case (cmd_i.step)
          STEP_FIRST: begin
            d_q     <= {{(DIFF_W-32){1'b0}}, alpha_q};
            rnd31_q <= 1'b0;
          end
          STEP_MID: begin
            a2_q    <= prod_q[63:30];
            d_q     <= d_rl;
            rnd31_q <= 1'b1;
          end
          default: begin
            m1_q    <= {prod_q[PROD_W-1], prod_q[PROD_W-1:31]};
            mul_a_q <= a2_q;
            d_q     <= d_2;
            rnd31_q <= 1'b1;
          end
        endcase
      end else begin
        case (mode)
          MODE_FWD:  begin d_q <= d_rc; rnd31_q <= 1'b0; end
          MODE_LEAP: begin d_q <= d_rl; rnd31_q <= 1'b0; end
          MODE_FTCS, MODE_LAX: begin d_q <= d_rl; rnd31_q <= 1'b1; end
          default:   begin d_q <= d_cl; rnd31_q <= 1'b0; end
        endcase
      end
    end
    if (cmd_i.mul_lo) begin
      prod_q <= pp_ext + bias;
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + (pp_ext <<< 17);
    end
  end

  // final sum and saturation
  always_comb begin
    if (lw) begin
      m1 = m1_q;
      m2 = {prod_q[PROD_W-1], prod_q[PROD_W-1:31]};
    end else begin
      m1 = rnd31_q ? {prod_q[PROD_W-1], prod_q[PROD_W-1:31]} : prod_q[PROD_W-1:30];
      m2 = '0;
    end
  end
  assign v      = base_q - m1 + m2;
  assign sat_hi = !v[SUM_W-1] && (v[SUM_W-2:VAL_W-1] != '0);
  assign sat_lo =  v[SUM_W-1] && (v[SUM_W-2:VAL_W-1] != '1);

  always_comb begin
    case (cmd_i.res_sel)
      RES_LAST: idx = IDX_W'(cnt_q);
      RES_WRAP: idx = '0;
      default:  idx = IDX_W'(cnt_q - CNT_W'(1));
    endcase
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q  <= sample_value_i;
      old_q  <= older_value_i;
      last_q <= last_point_i || (cnt_q >= CNT_W'(MAX_POINTS - 1));
    end
  end

  // window and point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q           <= '0;
      first_sample_q  <= '0;
      second_sample_q <= '0;
      first_older_q   <= '0;
      wb2_q           <= '0;
      wb1_q           <= '0;
      ob1_q           <= '0;
    end else if (cmd_i.short_out) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      if (cnt_q == '0) begin
        first_sample_q <= cur_q;
        first_older_q  <= old_q;
      end
      if (cnt_q == CNT_W'(1)) begin
        second_sample_q <= cur_q;
      end
      wb2_q <= wb1_q;
      wb1_q <= cur_q;
      ob1_q <= old_q;
      cnt_q <= last_q ? '0 : cnt_q + CNT_W'(1);
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out || cmd_i.short_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.short_out) begin
      idx_q   <= '0;
      val_q   <= '0;
      done_q  <= 1'b1;
      sat_q   <= 1'b0;
      short_q <= 1'b1;
    end else if (cmd_i.load_out) begin
      idx_q   <= idx;
      done_q  <= (cmd_i.res_sel == RES_WRAP);
      sat_q   <= sat_hi || sat_lo;
      short_q <= 1'b0;
      if (sat_hi) begin
        val_q <= 32'sh7FFF_FFFF;
      end else if (sat_lo) begin
        val_q <= 32'sh8000_0000;
      end else begin
        val_q <= v[VAL_W-1:0];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_index_o = idx_q;
  assign new_value_o   = val_q;
  assign pass_done_o   = done_q;
  assign saturated_o   = sat_q;
  assign short_pass_o  = short_q;

endmodule

// ===== sim/tb_periodic_advection_stencil_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench of periodic_advection_stencil_core: a directed table, random passes,
// a back-pressure burst and a closing pass, all checked against a bit-exact predictor
// depends on pasc_pkg and periodic_advection_stencil_core
module tb_periodic_advection_stencil_core;
  import pasc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int END_CYCLES    = 40;
  localparam int HOLD_CYCLES   = 80;
  localparam int NUM_ROWS      = 34;
  localparam int MAX_SHOWN     = 10;

  // register indexes with no register behind them
  localparam logic [1:0] CFG_SPARE2 = 2'd2;
  localparam logic [1:0] CFG_SPARE3 = 2'd3;
  // reserved scheme codes
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic [11:0] idx;
    logic [31:0] val;
    logic        done;
    logic        sat;
    logic        shrt;
  } result_t;

  localparam result_t SHORT_WORD = {12'd0, 32'd0, 1'b1, 1'b0, 1'b1};

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_data;
    logic [31:0] sample;
    logic [31:0] older;
    logic        last;
    logic        typed;
    result_t     want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] sample_value_i;
  logic signed [31:0] older_value_i;
  logic               last_point_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [11:0]        point_index_o;
  logic signed [31:0] new_value_o;
  logic               pass_done_o;
  logic               saturated_o;
  logic               short_pass_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  periodic_advection_stencil_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_value_i (sample_value_i),
    .older_value_i  (older_value_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_index_o  (point_index_o),
    .new_value_o    (new_value_o),
    .pass_done_o    (pass_done_o),
    .saturated_o    (saturated_o),
    .short_pass_o   (short_pass_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // mirror of the configuration and of the grid window
  logic [2:0]         scheme_q    = MODE_UPWIND;
  logic [31:0]        alpha_q     = ALPHA_RESET;
  logic signed [31:0] first_s     = '0;
  logic signed [31:0] second_s    = '0;
  logic signed [31:0] first_o     = '0;
  logic signed [31:0] back_two    = '0;
  logic signed [31:0] back_one    = '0;
  logic signed [31:0] older_one   = '0;
  int                 grid_count  = 0;

  result_t fresh_words[$];
  result_t pending_words[$];
  int      mismatches  = 0;
  int      points_fed  = 0;
  int      hold_cycles = 0;
  int      cycle_cnt   = 0;
  bit      idle_en     = 1'b1;

  // floor((a*d + 2^(s-1)) / 2^s), exact
  function automatic logic signed [95:0] mul_rnd(input logic [63:0] a,
                                                 input logic signed [95:0] d, input int s);
    logic signed [95:0] p;
    p = $signed({32'd0, a}) * d;
    return (p + (96'sd1 <<< (s - 1))) >>> s;
  endfunction

  // new value of center point c from neighbors l, r and older value o
  function automatic result_t next_level_value(input logic signed [31:0] l, c, r, o,
                                               input logic [11:0] idx, input logic done);
    logic signed [95:0] wl, wc, wr, wo, v;
    logic [63:0]        a2;
    result_t            res;
    wl = 96'(l);
    wc = 96'(c);
    wr = 96'(r);
    wo = 96'(o);
    case (scheme_q)
      MODE_FWD:  v = wc - mul_rnd(64'(alpha_q), wr - wc, 30);
      MODE_FTCS: v = wc - mul_rnd(64'(alpha_q), wr - wl, 31);
      MODE_LEAP: v = wo - mul_rnd(64'(alpha_q), wr - wl, 30);
      MODE_LW: begin
        a2 = (64'(alpha_q) * 64'(alpha_q) + 64'h2000_0000) >> 30;
        v = wc - mul_rnd(64'(alpha_q), wr - wl, 31) + mul_rnd(a2, wr - (wc + wc) + wl, 31);
      end
      MODE_LAX:  v = ((wr + wl + 96'sd1) >>> 1) - mul_rnd(64'(alpha_q), wr - wl, 31);
      default:   v = wc - mul_rnd(64'(alpha_q), wc - wl, 30);
    endcase
    res.sat = 1'b0;
    if (v > 96'sd2147483647) begin
      v = 96'sd2147483647;
      res.sat = 1'b1;
    end else if (v < -96'sd2147483648) begin
      v = -96'sd2147483648;
      res.sat = 1'b1;
    end
    res.idx  = idx;
    res.val  = v[31:0];
    res.done = done;
    res.shrt = 1'b0;
    return res;
  endfunction

  // one grid point enters; words it causes land in fresh_words
  function automatic void advance_grid(input logic signed [31:0] cur, old, input logic last_in);
    int   n;
    logic last;
    n    = grid_count;
    last = last_in || (n >= MAX_POINTS - 1);
    fresh_words.delete();
    if (last && n < 2) begin
      fresh_words.push_back(SHORT_WORD);
      grid_count = 0;
      return;
    end
    if (n == 0) begin
      first_s = cur;
      first_o = old;
    end else if (n == 1) begin
      second_s = cur;
    end
    if (n >= 2) begin
      fresh_words.push_back(next_level_value(back_two, back_one, cur, older_one,
                                             12'(n - 1), 1'b0));
    end
    if (last) begin
      fresh_words.push_back(next_level_value(back_one, cur, first_s, old, 12'(n), 1'b0));
      fresh_words.push_back(next_level_value(cur, first_s, second_s, first_o, 12'd0, 1'b1));
    end
    back_two   = back_one;
    back_one   = cur;
    older_one  = old;
    grid_count = last ? 0 : n + 1;
  endfunction

  function automatic row_t point_row(input logic [31:0] s, o, input logic l, input logic typed);
    row_t r;
    r        = '0;
    r.kind   = ROW_POINT;
    r.sample = s;
    r.older  = o;
    r.last   = l;
    r.typed  = typed;
    r.want   = typed ? SHORT_WORD : '0;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
    row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // directed stimulus table
  function automatic row_t directed_row(input int k);
    row_t r;
    case (k)
      // one-point and two-point passes right after reset
      0:  r = point_row(32'h0100_0000, 32'h5a5a_5a5a, 1'b1, 1'b1);
      1:  r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0);
      2:  r = point_row(32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b1);
      // upwind at reset alpha, extreme values
      3:  r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0);
      4:  r = point_row(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
      5:  r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
      // forward, largest alpha
      6:  r = cfg_row(CFG_MODE, {29'd0, MODE_FWD});
      7:  r = cfg_row(CFG_ALPHA, 32'hffff_ffff);
      8:  r = point_row(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0);
      9:  r = point_row(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0);
      10: r = point_row(32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
      // ftcs
      11: r = cfg_row(CFG_MODE, {29'd0, MODE_FTCS});
      12: r = point_row(32'h0100_0000, 32'h8000_0000, 1'b0, 1'b0);
      13: r = point_row(32'hff00_0000, 32'h7fff_ffff, 1'b0, 1'b0);
      14: r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
      // leapfrog with extreme older values
      15: r = cfg_row(CFG_MODE, {29'd0, MODE_LEAP});
      16: r = point_row(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0);
      17: r = point_row(32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0);
      18: r = point_row(32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
      // lax-wendroff
      19: r = cfg_row(CFG_MODE, {29'd0, MODE_LW});
      20: r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0);
      21: r = point_row(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
      22: r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
      // lax with alpha zero
      23: r = cfg_row(CFG_MODE, {29'd0, MODE_LAX});
      24: r = cfg_row(CFG_ALPHA, 32'h0000_0000);
      25: r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0);
      26: r = point_row(32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0);
      27: r = point_row(32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
      // reserved scheme, writes to spare indexes must not land anywhere
      28: r = cfg_row(CFG_MODE, {29'd0, MODE_RSVD6});
      29: r = cfg_row(CFG_SPARE2, 32'hffff_ffff);
      30: r = cfg_row(CFG_SPARE3, 32'h0000_0000);
      31: r = point_row(32'h0200_0000, 32'h1234_5678, 1'b0, 1'b0);
      32: r = point_row(32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0);
      default: r = point_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    endcase
    return r;
  endfunction

  // mostly smooth values near zero, some full range, some extremes
  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      2:    v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void report_word(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%s: want idx %0d val %h done %b sat %b short %b", what,
               want.idx, want.val, want.done, want.sat, want.shrt);
      $display("%s:  got idx %0d val %h done %b sat %b short %b", what,
               got.idx, got.val, got.done, got.sat, got.shrt);
    end
  endfunction

  // offer one word and hold it until taken, then predict and maybe idle
  task automatic feed_point(input logic [31:0] s, o, input logic l, input logic typed,
                            input result_t want);
    in_valid_i     <= 1'b1;
    sample_value_i <= s;
    older_value_i  <= o;
    last_point_i   <= l;
    do @(posedge clk_i); while (!in_ready_o);
    advance_grid(s, o, l);
    if (typed) begin
      pending_words.push_back(want);
    end else begin
      foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    end
    points_fed++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // stop offering, wait for every expected word, then let warm-up points finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CFG_MODE) begin
      scheme_q = data[2:0];
    end else if (idx == CFG_ALPHA) begin
      alpha_q = data;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_periodic_advection_stencil_core NOT OK");
    $finish;
  end

  // result side: check taken words, stall in bursts or on a long hold
  initial begin : result_side
    int      stall_left;
    result_t got;
    stall_left  = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {point_index_o, new_value_o, pass_done_o, saturated_o, short_pass_o};
        if (pending_words.size() == 0) begin
          report_word("unexpected word", '0, got);
        end else if (got !== pending_words[0]) begin
          report_word("wrong word", pending_words.pop_front(), got);
        end else begin
          void'(pending_words.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left  = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : main_flow
    row_t        row;
    int          start_cnt;
    int          pass_len;
    logic [2:0]  mode_pick;
    logic [31:0] alpha_pick;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    sample_value_i <= '0;
    older_value_i  <= '0;
    last_point_i   <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_MODE;
    cfg_data_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // directed table
    for (int k = 0; k < NUM_ROWS; k++) begin
      row = directed_row(k);
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        feed_point(row.sample, row.older, row.last, row.typed, row.want);
      end
    end

    // random passes under random settings
    start_cnt = points_fed;
    while (points_fed - start_cnt < RANDOM_ITEMS) begin
      settle();
      mode_pick = 3'($urandom_range(0, 7));
      write_reg(CFG_MODE, ($urandom_range(0, 1) ? ($urandom & ~32'd7) : 32'd0) |
                          {29'd0, mode_pick});
      case ($urandom_range(0, 4))
        0:       alpha_pick = 32'h0000_0000;
        1:       alpha_pick = 32'hffff_ffff;
        2:       alpha_pick = 32'h4000_0000;
        3:       alpha_pick = ALPHA_RESET;
        default: alpha_pick = $urandom;
      endcase
      write_reg(CFG_ALPHA, alpha_pick);
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3, $urandom);
      end
      repeat ($urandom_range(1, 3)) begin
        pass_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        for (int k = 0; k < pass_len; k++) begin
          feed_point(rand_value(), rand_value(), k == pass_len - 1, 1'b0, '0);
        end
      end
    end

    // back-pressure: results held off while points keep coming
    settle();
    idle_en = 1'b0;
    write_reg(CFG_MODE, {29'd0, MODE_LW});
    write_reg(CFG_ALPHA, $urandom);
    @(negedge clk_i);
    hold_cycles = HOLD_CYCLES;
    @(posedge clk_i);
    for (int k = 0; k < 12; k++) begin
      feed_point(rand_value(), rand_value(), k == 11, 1'b0, '0);
    end
    settle();

    // closing pass at reset alpha
    write_reg(CFG_MODE, {29'd0, MODE_FTCS});
    write_reg(CFG_ALPHA, ALPHA_RESET);
    for (int k = 0; k < 3; k++) begin
      feed_point(rand_value(), rand_value(), k == 2, 1'b0, '0);
    end

    // drain and report
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_periodic_advection_stencil_core OK");
    end else begin
      $display("tb_periodic_advection_stencil_core NOT OK");
    end
    $finish;
  end

endmodule
